[hw/rtl/fcd_pkg.sv]
package fcd_pkg;

  localparam int CFG_W   = 11;
  localparam int COORD_W = 10;
  localparam int CELL_W  = 8;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int CLS_W   = 2;
  localparam int WIN_W   = 9 * CLS_W;

  typedef enum logic [CLS_W-1:0] {
    CLS_OTHER   = 2'd0,
    CLS_FREE    = 2'd1,
    CLS_UNKNOWN = 2'd2
  } fcd_cls_t;

  typedef enum logic {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } fcd_reg_t;

  localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;
  localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic               last;
    logic               have_window;
    logic [COORD_W-1:0] ccol;
    logic [COORD_W-1:0] crow;
  } fcd_item_t;

  function automatic logic [CLS_W-1:0] classify(input logic [CELL_W-1:0] v);
    logic [CLS_W-1:0] c;
    if (v == CELL_FREE) begin
      c = CLS_FREE;
    end else if (v == CELL_UNKNOWN) begin
      c = CLS_UNKNOWN;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

[hw/rtl/frontier_cell_detect.sv]
// Channel  | Handshake                  | Payload
// cell     | cell_valid / cell_ready    | cell_value
// result   | result_valid / result_ready| center_col, center_row, is_frontier, frame_end
// config   | APB write, pready always 1 | map_width at 0x0, map_height at 0x4
//
// One cell is taken every cycle unless a stalled result holds it off; a result is registered
// only for a frontier cell or the last cell, after a buffer stage and the line store read.
// Reset clears the position, the window and both valid flags, with no clearing pass.
// A stalled result holds the pipeline and drops cell_ready; nothing is lost.
module frontier_cell_detect import fcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                cell_valid,
  output logic                cell_ready,
  input  logic [CELL_W-1:0]   cell_value,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [COORD_W-1:0]  center_col,
  output logic [COORD_W-1:0]  center_row,
  output logic                is_frontier,
  output logic                frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0]   map_width;
  logic [CFG_W-1:0]   map_height;
  logic               cfg_wr;
  logic               nonempty;
  logic               load;
  logic [AW-1:0]      col_addr;
  fcd_item_t          item;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [2*CLS_W-1:0] ram_wdata;
  logic [2*CLS_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign load = cell_valid && cell_ready && nonempty;

  always_comb begin
    case (fcd_reg_t'(paddr[2]))
      REG_MAP_WIDTH:  prdata = APB_DW'(map_width);
      REG_MAP_HEIGHT: prdata = APB_DW'(map_height);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= '0;
      map_height <= '0;
    end else if (cfg_wr) begin
      case (fcd_reg_t'(paddr[2]))
        REG_MAP_WIDTH:  map_width <= pwdata[CFG_W-1:0];
        REG_MAP_HEIGHT: map_height <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fcd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .map_width  (map_width),
    .map_height (map_height),
    .clear      (cfg_wr),
    .advance    (load),
    .cell_value (cell_value),
    .nonempty   (nonempty),
    .col_addr   (col_addr),
    .item       (item)
  );

  fcd_ram #(
    .WIDTH (2 * CLS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (load),
    .raddr (col_addr),
    .rdata (ram_rdata)
  );

  fcd_window #(
    .AW (AW)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .item         (item),
    .col_addr     (col_addr),
    .take_ready   (cell_ready),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .center_col   (center_col),
    .center_row   (center_row),
    .is_frontier  (is_frontier),
    .frame_end    (frame_end)
  );

endmodule

[hw/rtl/fcd_ram.sv]
module fcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fcd_scan.sv]
module fcd_scan import fcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [CFG_W-1:0]             map_width,
  input  logic [CFG_W-1:0]             map_height,
  input  logic                         clear,
  input  logic                         advance,
  input  logic [CELL_W-1:0]            cell_value,
  output logic                         nonempty,
  output logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  output fcd_item_t                    item
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WUW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HUW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [CW-1:0]  col_next;
  logic [RW-1:0]  row_next;
  logic [WUW-1:0] w_used;
  logic [HUW-1:0] h_used;
  logic [WUW-1:0] col_inc;
  logic [HUW-1:0] row_inc;
  logic           row_end;
  logic           last;
  logic           have_window;
  logic [CXW-1:0] ccol_full;
  logic [RXW-1:0] crow_full;

  always_comb begin
    w_used = (WUW'(map_width) > WUW'(MAX_WIDTH)) ? WUW'(MAX_WIDTH) : WUW'(map_width);
    h_used = (HUW'(map_height) > HUW'(MAX_HEIGHT)) ? HUW'(MAX_HEIGHT) : HUW'(map_height);
    nonempty = (w_used != '0) && (h_used != '0);
    col_inc = WUW'(col) + WUW'(1);
    row_inc = HUW'(row) + HUW'(1);
    row_end = col_inc >= w_used;
    last = row_end && (row_inc >= h_used);
    have_window = (col >= CW'(2)) && (row >= RW'(2));
    ccol_full = CXW'(col) - CXW'(1);
    crow_full = RXW'(row) - RXW'(1);
    item.cls = classify(cell_value);
    item.last = last;
    item.have_window = have_window;
    item.ccol = have_window ? ccol_full[COORD_W-1:0] : '0;
    item.crow = have_window ? crow_full[COORD_W-1:0] : '0;
    col_addr = col;
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (clear) begin
      col_next = '0;
      row_next = '0;
    end else if (advance) begin
      if (row_end) begin
        col_next = '0;
        row_next = last ? '0 : row_inc[RW-1:0];
      end else begin
        col_next = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && last) |=> (col == '0 && row == '0))
    else $error("scan position did not wrap after the last cell");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    nonempty |-> (WUW'(col) < w_used))
    else $error("column position beyond the map width");

endmodule

[hw/rtl/fcd_window.sv]
module fcd_window import fcd_pkg::*; #(
  parameter int AW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  fcd_item_t            item,
  input  logic [AW-1:0]        col_addr,
  output logic                 take_ready,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [2*CLS_W-1:0]   ram_wdata,
  input  logic [2*CLS_W-1:0]   ram_rdata,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [COORD_W-1:0]   center_col,
  output logic [COORD_W-1:0]   center_row,
  output logic                 is_frontier,
  output logic                 frame_end
);

  logic               b_valid;
  fcd_item_t          b_item;
  logic [AW-1:0]      b_addr;
  logic [WIN_W-1:0]   window;
  logic [WIN_W-1:0]   window_next;
  logic               b_adv;
  logic               unknown_near;
  logic               frontier;
  logic               emit;

  always_comb begin
    window_next = {window[WIN_W-3*CLS_W-1:0], ram_rdata, b_item.cls};
    unknown_near = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && window_next[CLS_W*k +: CLS_W] == CLS_UNKNOWN) begin
        unknown_near = 1'b1;
      end
    end
    frontier = b_item.have_window && (window_next[CLS_W*4 +: CLS_W] == CLS_FREE) &&
               unknown_near;
    emit = frontier || b_item.last;
    b_adv = b_valid && (!result_valid || result_ready);
    take_ready = !b_valid || b_adv;
    ram_we = b_adv;
    ram_waddr = b_addr;
    ram_wdata = {ram_rdata[CLS_W-1:0], b_item.cls};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      window <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take_ready) begin
        b_valid <= load;
      end
      if (b_adv) begin
        window <= window_next;
        result_valid <= emit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_ready && load) begin
      b_item <= item;
      b_addr <= col_addr;
    end
    if (b_adv) begin
      center_col <= b_item.ccol;
      center_row <= b_item.crow;
      is_frontier <= frontier;
      frame_end <= b_item.last;
    end
  end

  a_stall_only_on_output: assert property (@(posedge clk) disable iff (rst)
    !take_ready |-> (result_valid && !result_ready))
    else $error("input held off without an output stall");

endmodule
